/* rtl/core/url_percent_decoder_assert.svh */
// Assertion macros shared by the URL percent decoder checkers.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, off during reset
`define UPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/upd_pkg.sv */
// Package for the URL percent decoder: types, constants and hex helpers.
// No dependencies; used by every module of the decoder.
package upd_pkg;

    localparam logic [7:0] UPD_PCT_CHAR    = 8'h25;
    localparam int         UPD_MAX_RESULTS = 3;
    localparam int         UPD_QUEUE_DEPTH = 4;

    // Escape progress of the front end
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } upd_phase_t;

    // Up to three output bytes caused by one input item
    typedef struct packed {
        logic [1:0]                        cnt;
        logic [UPD_MAX_RESULTS-1:0][7:0]   chars;
        logic                              last;
    } upd_bundle_t;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c - 8'h30;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            v = c - 8'h37;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            v = c - 8'h57;
        end
        hex_nib = v[3:0];
    endfunction

endpackage

/* rtl/core/upd_front.sv */
// Front end of the URL percent decoder: accepts bytes, tracks escapes,
// and builds one bundle of output bytes per item. Depends on upd_pkg.
module upd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         in_char,
    input  logic               in_last,
    output logic               push,
    output upd_pkg::upd_bundle_t push_data
);
    import upd_pkg::*;

    upd_phase_t  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        accept;
    logic        c_hex;
    logic        c_pct;
    upd_bundle_t b;

    assign accept = in_valid && !in_stall;
    assign c_hex  = hex_ok(in_char);
    assign c_pct  = (in_char == UPD_PCT_CHAR) && !in_last;

    // Next escape phase and held digit
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (c_hex && !in_last)
                begin
                    held_next  = in_char;
                    phase_next = PH_DIGIT;
                end
                else if (c_hex)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = c_pct ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT:
            begin
                if (c_hex)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = c_pct ? PH_PCT : PH_IDLE;
                end
            end
            default:
            begin
                phase_next = c_pct ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    // Build the bundle of output bytes for this item
    always_comb
    begin
        b       = '0;
        b.last  = in_last;
        case (phase_reg)
            PH_PCT:
            begin
                if (c_hex)
                begin
                    if (in_last)
                    begin
                        b.chars[0] = UPD_PCT_CHAR;
                        b.chars[1] = in_char;
                        b.cnt      = 2'd2;
                    end
                end
                else if (c_pct)
                begin
                    b.chars[0] = UPD_PCT_CHAR;
                    b.cnt      = 2'd1;
                    b.last     = 1'b0;
                end
                else
                begin
                    b.chars[0] = UPD_PCT_CHAR;
                    b.chars[1] = in_char;
                    b.cnt      = 2'd2;
                end
            end
            PH_DIGIT:
            begin
                if (c_hex)
                begin
                    b.chars[0] = {hex_nib(held_reg), hex_nib(in_char)};
                    b.cnt      = 2'd1;
                end
                else if (c_pct)
                begin
                    b.chars[0] = UPD_PCT_CHAR;
                    b.chars[1] = held_reg;
                    b.cnt      = 2'd2;
                    b.last     = 1'b0;
                end
                else
                begin
                    b.chars[0] = UPD_PCT_CHAR;
                    b.chars[1] = held_reg;
                    b.chars[2] = in_char;
                    b.cnt      = 2'd3;
                end
            end
            default:
            begin
                if (!c_pct)
                begin
                    b.chars[0] = in_char;
                    b.cnt      = 2'd1;
                end
            end
        endcase
    end

    // Advance the escape state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Drop bundles that carry no byte
    assign push      = accept && (b.cnt != 2'd0);
    assign push_data = b;

endmodule

/* rtl/core/upd_queue.sv */
// Short bundle queue between front and back ends of the decoder.
// Depends on upd_pkg for the bundle type.
module upd_queue #(
    parameter int DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  upd_pkg::upd_bundle_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output upd_pkg::upd_bundle_t head_data
);
    import upd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_bundle_t   slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slots[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed bundles
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/upd_back.sv */
// Back end of the URL percent decoder: unpacks bundles into output items
// through a registered output stage. Depends on upd_pkg.
module upd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  upd_pkg::upd_bundle_t head_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_char,
    output logic                 out_last
);
    import upd_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       load;
    logic       at_end;

    // Load a byte when the output register is free or being taken
    assign load   = head_valid && (!out_valid_reg || !out_stall);
    assign at_end = (idx_reg == head_data.cnt - 2'd1);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold output payload while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= head_data.chars[idx_reg];
            out_last_reg <= head_data.last && at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/core/url_percent_decoder.sv */
// Channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | in_char[7:0], in_last
// out     | output    | out_valid / out_stall | out_char[7:0], out_last
//
// Takes one byte per cycle while the queue is not full; a byte that yields one
// output item flows at one item per cycle while out_stall is low. A byte that
// breaks an escape yields one to three items; the bundle queue absorbs bursts.
// Input stalls only when the queue is full.
// Reset is asynchronous, active low, and clears escape state and the queue.
//
// Top level of the URL percent decoder: front end, bundle queue, back end.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last
);
    import upd_pkg::*;

    logic        push;
    upd_bundle_t push_data;
    logic        pop;
    logic        full;
    logic        head_valid;
    upd_bundle_t head_data;

    assign in_stall = full;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .in_last   (in_last),
        .push      (push),
        .push_data (push_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last)
    );

endmodule

/* rtl/core/upd_checker.sv */
// Port-level checker for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_assert.svh.
module upd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_char,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       out_last
);
`include "url_percent_decoder_assert.svh"

    // Hold a stalled output item
    `UPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_char) && $stable(out_last), "output item changed under stall")

    // A full queue always has an item on the output
    `UPD_ASSERT_NOW(a_stall_has_out, in_stall, out_valid, "input stalled with no output item")

    // Draining from a full queue keeps the output busy
    `UPD_ASSERT_NEXT(a_drain_refill, in_stall && !out_stall, out_valid,
        "output went idle while queue held items")

endmodule

bind url_percent_decoder upd_checker u_chk (.*);

/* test/url_percent_decoder_test.sv */
// Self-checking bench for url_percent_decoder: a directed run, then random escape strings.
// Depends on upd_pkg for the escape phase type and the percent character.

class decode_scoreboard;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_item_t;

    upd_pkg::upd_phase_t phase;
    logic [7:0]          first_digit;
    byte_item_t          expected_q[$];
    int                  errors;

    function new();
        phase       = upd_pkg::PH_IDLE;
        first_digit = 8'h00;
        errors      = 0;
    endfunction

    // True for 0-9, A-F and a-f
    function bit is_hex(logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 1'b1;
        end
        return (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)
            ? (folded >= 8'h61 && folded <= 8'h66) : 1'b0;
    endfunction

    // Value of one hex digit; caller has checked is_hex
    function logic [3:0] nibble(logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return 4'(folded - 8'h61 + 8'd10);
    endfunction

    function void emit(logic [7:0] c, logic l);
        byte_item_t it;
        it.ch   = c;
        it.last = l;
        expected_q = {expected_q, it};
    endfunction

    // Handle a byte with no escape pending
    function void take_plain(logic [7:0] c, logic l);
        if (c == upd_pkg::UPD_PCT_CHAR && !l)
        begin
            phase = upd_pkg::PH_PCT;
        end
        else
        begin
            phase = upd_pkg::PH_IDLE;
            emit(c, l);
        end
    endfunction

    // Advance the escape state by one accepted input item
    function void note_input(logic [7:0] c, logic l);
        case (phase)
            upd_pkg::PH_PCT:
            begin
                if (is_hex(c))
                begin
                    if (l)
                    begin
                        emit(upd_pkg::UPD_PCT_CHAR, 1'b0);
                        emit(c, 1'b1);
                        phase = upd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        first_digit = c;
                        phase       = upd_pkg::PH_DIGIT;
                    end
                end
                else
                begin
                    emit(upd_pkg::UPD_PCT_CHAR, 1'b0);
                    take_plain(c, l);
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (is_hex(c))
                begin
                    emit({nibble(first_digit), nibble(c)}, l);
                    phase = upd_pkg::PH_IDLE;
                end
                else
                begin
                    emit(upd_pkg::UPD_PCT_CHAR, 1'b0);
                    emit(first_digit, 1'b0);
                    take_plain(c, l);
                end
            end
            default:
            begin
                take_plain(c, l);
            end
        endcase
    endfunction

    // Compare one output item with the oldest expected byte
    function void check_output(logic [7:0] c, logic l);
        byte_item_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected output item: expected none, actual char %h last %b",
                     $time, c, l);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (c !== want.ch)
        begin
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, c);
            errors++;
        end
        if (l !== want.last)
        begin
            $display("%0t: out_last mismatch: expected %b, actual %b", $time, want.last, l);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

endclass

module url_percent_decoder_test;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_char   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_last;

    bit               calm       = 1'b0;
    int               items_sent = 0;
    decode_scoreboard sb         = new();

    url_percent_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both channels on every rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_input(in_char, in_last);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_output(out_char, out_last);
            end
        end
    end

    // Stall the output in random bursts, none once the run goes calm
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Drop valid for a random burst now and then
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Offer one item and hold it until accepted
    task automatic send_item(logic [7:0] c, logic l);
        maybe_idle();
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], i == s.len() - 1);
        end
    endtask

    // Hold off the input until every expected byte has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789ABCDEFabcdef";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Build one string, mostly good escapes, some broken ones and raw noise
    task automatic send_random_string();
        logic [7:0] text[$];
        int         pieces;
        int         kind;
        pieces = $urandom_range(1, 6);
        repeat (pieces)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4)
            begin
                text = {text, upd_pkg::UPD_PCT_CHAR};
                text = {text, rand_hex()};
                text = {text, rand_hex()};
            end
            else if (kind <= 6)
            begin
                text = {text, 8'($urandom_range(0, 255))};
            end
            else if (kind == 7)
            begin
                text = {text, upd_pkg::UPD_PCT_CHAR};
                text = {text, 8'($urandom_range(0, 255))};
            end
            else if (kind == 8)
            begin
                text = {text, upd_pkg::UPD_PCT_CHAR};
                text = {text, rand_hex()};
                if ($urandom_range(0, 1) == 1)
                begin
                    text = {text, 8'($urandom_range(0, 255))};
                end
            end
            else
            begin
                text = {text, upd_pkg::UPD_PCT_CHAR};
            end
        end
        foreach (text[i])
        begin
            send_item(text[i], i == text.size() - 1);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: good escapes, byte extremes, each way an escape can break
        send_text("%41");
        send_text("%Ff");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_text("%");
        send_text("%4");
        send_text("%g/");
        send_text("%%41");
        send_text("%4G");
        send_text("%4%");
        send_text("%`@");
        send_text("%00");
        wait_drained();

        // Random strings; go calm near the end
        while (items_sent < 320)
        begin
            if (items_sent >= 260)
            begin
                calm = 1'b1;
            end
            send_random_string();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
